@@ src/slit_pkg.sv @@
package slit_pkg;

    localparam int CAPACITY_DEF  = 1024;
    localparam int LINE_BITS_DEF = 24;
    localparam int MODE_W        = 3;
    localparam int RANK_W        = 10;
    localparam int STATUS_W      = 3;
    localparam int TOTAL_W       = 11;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT  = 3'd0,
        MODE_REMOVE  = 3'd1,
        MODE_RANK_OF = 3'd2,
        MODE_SELECT  = 3'd3,
        MODE_SUCC    = 3'd4,
        MODE_CLEAR   = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_PRESENT = 3'd1,
        ST_ABSENT  = 3'd2,
        ST_FULL    = 3'd3,
        ST_RANGE   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SRCH_RD,
        OP_SRCH_UPD,
        OP_PROBE_RD,
        OP_IDX_INIT,
        OP_SHIFT_RD,
        OP_SHIFT_WR,
        OP_PUT,
        OP_SEL_RD,
        OP_FIN
    } cmd_op_t;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_op_t;

    typedef struct packed {
        status_t status;
        logic    line_from_data;
        logic    rank_from_pos;
        cnt_op_t cnt_op;
    } fin_t;

    typedef struct packed {
        cmd_op_t op;
        fin_t    fin;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic lo_lt_hi;
        logic data_lt_key;
        logic data_eq_key;
        logic pos_lt_count;
        logic rank_lt_count;
        logic full;
        logic shift_done;
        logic out_busy;
    } sts_t;

endpackage

@@ src/slit_ram.sv @@
module slit_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/slit_datapath.sv @@
module slit_datapath
    import slit_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [MODE_W-1:0]    mode,
    input  logic [LINE_BITS-1:0] line,
    input  logic [RANK_W-1:0]    rank,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [STATUS_W-1:0]  status,
    output logic [LINE_BITS-1:0] result_line,
    output logic [RANK_W-1:0]    result_rank,
    output logic [TOTAL_W-1:0]   entry_total
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > RANK_W) ? CNT_W : RANK_W;
    localparam int TOT_W  = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;

    logic [MODE_W-1:0]    mode_reg;
    logic [LINE_BITS-1:0] key_reg;
    logic [RANK_W-1:0]    rank_reg;
    logic [CNT_W-1:0]     lo_reg, hi_reg, idx_reg, count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [LINE_BITS-1:0] result_line_reg;
    logic [RANK_W-1:0]    result_rank_reg;
    logic [TOTAL_W-1:0]   entry_total_reg;

    logic [CNT_W:0]       mid_sum;
    logic [CNT_W-1:0]     mid, idx_m1, idx_p1;
    logic [CMP_W-1:0]     rank_ext, lo_ext, count_ext;
    logic [TOT_W-1:0]     total_ext;
    logic                 is_insert;

    logic                 wr_en, rd_en;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic [LINE_BITS-1:0] wr_data, rd_data;

    slit_ram #(.WIDTH(LINE_BITS), .DEPTH(CAPACITY)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[CNT_W:1];
    assign idx_m1    = idx_reg - 1'b1;
    assign idx_p1    = idx_reg + 1'b1;
    assign rank_ext  = CMP_W'(rank_reg);
    assign lo_ext    = CMP_W'(lo_reg);
    assign count_ext = CMP_W'(count_reg);
    assign total_ext = TOT_W'(count_next);
    assign is_insert = (mode_reg == MODE_INSERT);

    always_comb
    begin
        sts.mode          = mode_reg;
        sts.lo_lt_hi      = (lo_reg < hi_reg);
        sts.data_lt_key   = (rd_data < key_reg);
        sts.data_eq_key   = (rd_data == key_reg);
        sts.pos_lt_count  = (lo_reg < count_reg);
        sts.rank_lt_count = (rank_ext < count_ext);
        sts.full          = (count_reg >= CNT_W'(CAPACITY));
        sts.shift_done    = is_insert ? (idx_reg == lo_reg) : (idx_p1 >= count_reg);
        sts.out_busy      = out_valid_reg && out_stall;
    end

    // at most one memory access per command
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rd_data;
        case (cmd.op)
            OP_SRCH_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = mid[ADDR_W-1:0];
            end
            OP_PROBE_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = lo_reg[ADDR_W-1:0];
            end
            OP_SHIFT_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = is_insert ? idx_m1[ADDR_W-1:0] : idx_p1[ADDR_W-1:0];
            end
            OP_SHIFT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[ADDR_W-1:0];
            end
            OP_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = lo_reg[ADDR_W-1:0];
                wr_data = key_reg;
            end
            OP_SEL_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = rank_ext[ADDR_W-1:0];
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.fin.cnt_op)
            CNT_INC: count_next = count_reg + 1'b1;
            CNT_DEC: count_next = count_reg - 1'b1;
            CNT_CLR: count_next = '0;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.op == OP_FIN)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                mode_reg <= mode;
                key_reg  <= line;
                rank_reg <= rank;
                lo_reg   <= '0;
                hi_reg   <= count_reg;
            end
            OP_SRCH_UPD:
            begin
                if (sts.data_lt_key)
                begin
                    lo_reg <= mid + 1'b1;
                end
                else
                begin
                    hi_reg <= mid;
                end
            end
            OP_IDX_INIT:
            begin
                idx_reg <= is_insert ? count_reg : lo_reg;
            end
            OP_SHIFT_WR:
            begin
                idx_reg <= is_insert ? idx_m1 : idx_p1;
            end
            OP_FIN:
            begin
                status_reg      <= cmd.fin.status;
                result_line_reg <= cmd.fin.line_from_data ? rd_data : '0;
                result_rank_reg <= cmd.fin.rank_from_pos ? lo_ext[RANK_W-1:0] : '0;
                entry_total_reg <= total_ext[TOTAL_W-1:0];
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign result_line = result_line_reg;
    assign result_rank = result_rank_reg;
    assign entry_total = entry_total_reg;

endmodule

@@ src/slit_ctrl.sv @@
module slit_ctrl
    import slit_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRCH,
        S_SRCH_CMP,
        S_PROBE,
        S_SHIFT,
        S_SHIFT_WR,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    fin_t   fin_reg, fin_next;
    logic   hit;

    assign hit      = sts.pos_lt_count && sts.data_eq_key;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        cmd.op     = OP_NONE;
        cmd.fin    = fin_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                fin_next   = '{ST_OK, 1'b0, 1'b0, CNT_KEEP};
                state_next = S_FIN;
                case (sts.mode)
                    MODE_INSERT, MODE_REMOVE, MODE_RANK_OF, MODE_SUCC:
                    begin
                        state_next = S_SRCH;
                    end
                    MODE_SELECT:
                    begin
                        if (sts.rank_lt_count)
                        begin
                            cmd.op   = OP_SEL_RD;
                            fin_next = '{ST_OK, 1'b1, 1'b0, CNT_KEEP};
                        end
                        else
                        begin
                            fin_next = '{ST_RANGE, 1'b0, 1'b0, CNT_KEEP};
                        end
                    end
                    MODE_CLEAR:
                    begin
                        fin_next = '{ST_OK, 1'b0, 1'b0, CNT_CLR};
                    end
                    default:
                    begin
                        fin_next = '{ST_OK, 1'b0, 1'b0, CNT_KEEP};
                    end
                endcase
            end
            S_SRCH:
            begin
                if (sts.lo_lt_hi)
                begin
                    cmd.op     = OP_SRCH_RD;
                    state_next = S_SRCH_CMP;
                end
                else
                begin
                    cmd.op     = OP_PROBE_RD;
                    state_next = S_PROBE;
                end
            end
            S_SRCH_CMP:
            begin
                cmd.op     = OP_SRCH_UPD;
                state_next = S_SRCH;
            end
            S_PROBE:
            begin
                state_next = S_FIN;
                case (sts.mode)
                    MODE_INSERT:
                    begin
                        if (hit)
                        begin
                            fin_next = '{ST_PRESENT, 1'b0, 1'b1, CNT_KEEP};
                        end
                        else if (sts.full)
                        begin
                            fin_next = '{ST_FULL, 1'b0, 1'b0, CNT_KEEP};
                        end
                        else
                        begin
                            cmd.op     = OP_IDX_INIT;
                            state_next = S_SHIFT;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (hit)
                        begin
                            cmd.op     = OP_IDX_INIT;
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            fin_next = '{ST_ABSENT, 1'b0, 1'b0, CNT_KEEP};
                        end
                    end
                    MODE_RANK_OF:
                    begin
                        if (hit)
                        begin
                            fin_next = '{ST_OK, 1'b0, 1'b1, CNT_KEEP};
                        end
                        else
                        begin
                            fin_next = '{ST_ABSENT, 1'b0, 1'b0, CNT_KEEP};
                        end
                    end
                    default:
                    begin
                        if (sts.pos_lt_count)
                        begin
                            fin_next = '{ST_OK, 1'b1, 1'b0, CNT_KEEP};
                        end
                        else
                        begin
                            fin_next = '{ST_ABSENT, 1'b0, 1'b0, CNT_KEEP};
                        end
                    end
                endcase
            end
            S_SHIFT:
            begin
                if (sts.shift_done)
                begin
                    state_next = S_FIN;
                    if (sts.mode == MODE_INSERT)
                    begin
                        cmd.op   = OP_PUT;
                        fin_next = '{ST_OK, 1'b0, 1'b1, CNT_INC};
                    end
                    else
                    begin
                        fin_next = '{ST_OK, 1'b0, 1'b0, CNT_DEC};
                    end
                end
                else
                begin
                    cmd.op     = OP_SHIFT_RD;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.op     = OP_SHIFT_WR;
                state_next = S_SHIFT;
            end
            S_FIN:
            begin
                if (!sts.out_busy)
                begin
                    cmd.op     = OP_FIN;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= '{ST_OK, 1'b0, 1'b0, CNT_KEEP};
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

@@ src/sorted_line_index_table.sv @@
// Channel  Dir  Handshake           Word
// in       in   in_valid/in_stall   mode, line, rank
// out      out  out_valid/out_stall status, result_line, result_rank, entry_total
//
// Steps of a request: accept and dispatch, a read and a compare per binary-search
// step, a probe read, then a read and a write per entry moved by an insert or
// remove, then the result. Set by the single RAM read port with registered read
// data. Clear and select go from dispatch straight to the result.
// Reset clears the count and the output valid; the line RAM is not cleared.
// A result held by out_stall stays in the output register; the next request
// is taken meanwhile and waits for that register before it finishes.
module sorted_line_index_table
    import slit_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [MODE_W-1:0]    mode,
    input  logic [LINE_BITS-1:0] line,
    input  logic [RANK_W-1:0]    rank,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATUS_W-1:0]  status,
    output logic [LINE_BITS-1:0] result_line,
    output logic [RANK_W-1:0]    result_rank,
    output logic [TOTAL_W-1:0]   entry_total
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: search, probe, shift, finish
    slit_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // line RAM, search bounds, shift index, count, output register
    slit_datapath #(.CAPACITY(CAPACITY), .LINE_BITS(LINE_BITS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (mode),
        .line        (line),
        .rank        (rank),
        .cmd         (cmd),
        .sts         (sts),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .status      (status),
        .result_line (result_line),
        .result_rank (result_rank),
        .entry_total (entry_total)
    );

    // a taken word keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after accept");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_RANGE))
        else $error("illegal status code");

    a_full_means_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (entry_total == TOTAL_W'(CAPACITY)))
        else $error("full status with count below capacity");

endmodule

@@ bench/slit_checker.sv @@
`timescale 1ns / 1ps

module slit_checker
    import slit_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [MODE_W-1:0]    mode,
    input  logic [LINE_BITS-1:0] line,
    input  logic [RANK_W-1:0]    rank,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [STATUS_W-1:0]  status,
    input  logic [LINE_BITS-1:0] result_line,
    input  logic [RANK_W-1:0]    result_rank,
    input  logic [TOTAL_W-1:0]   entry_total,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [LINE_BITS-1:0] line;
        logic [RANK_W-1:0]    rank;
        logic [TOTAL_W-1:0]   total;
    } answer_t;

    logic [LINE_BITS-1:0] shadow_lines [CAPACITY];
    int                   shadow_count;
    answer_t              answers_q [$];

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, field, got, want);
        fail_count++;
    endtask

    // Apply one request to the shadow table and return the expected word.
    function automatic answer_t serve_request(logic [MODE_W-1:0] req_mode,
                                              logic [LINE_BITS-1:0] key,
                                              logic [RANK_W-1:0] req_rank);
        answer_t a;
        int      pos;
        bit      hit;
        a   = '0;
        pos = 0;
        while (pos < shadow_count && shadow_lines[pos] < key)
            pos++;
        hit = (pos < shadow_count) && (shadow_lines[pos] == key);
        a.status = ST_OK;
        case (req_mode)
            MODE_INSERT:
            begin
                if (hit)
                begin
                    a.status = ST_PRESENT;
                    a.rank   = RANK_W'(pos);
                end
                else if (shadow_count >= CAPACITY)
                    a.status = ST_FULL;
                else
                begin
                    for (int i = shadow_count; i > pos; i--)
                        shadow_lines[i] = shadow_lines[i-1];
                    shadow_lines[pos] = key;
                    shadow_count++;
                    a.rank = RANK_W'(pos);
                end
            end
            MODE_REMOVE:
            begin
                if (!hit)
                    a.status = ST_ABSENT;
                else
                begin
                    for (int i = pos; i < shadow_count - 1; i++)
                        shadow_lines[i] = shadow_lines[i+1];
                    shadow_count--;
                end
            end
            MODE_RANK_OF:
            begin
                if (hit)
                    a.rank = RANK_W'(pos);
                else
                    a.status = ST_ABSENT;
            end
            MODE_SELECT:
            begin
                if (req_rank < shadow_count)
                    a.line = shadow_lines[req_rank];
                else
                    a.status = ST_RANGE;
            end
            MODE_SUCC:
            begin
                if (pos < shadow_count)
                    a.line = shadow_lines[pos];
                else
                    a.status = ST_ABSENT;
            end
            MODE_CLEAR:
                shadow_count = 0;
            default: ;
        endcase
        a.total = TOTAL_W'(shadow_count);
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            shadow_count = 0;
            answers_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (answers_q.size() == 0)
                    report("unexpected word", 32'(status), 32'd0);
                else
                begin
                    want = answers_q.pop_front();
                    if (status !== want.status)
                        report("status", 32'(status), 32'(want.status));
                    if (result_line !== want.line)
                        report("result_line", 32'(result_line), 32'(want.line));
                    if (result_rank !== want.rank)
                        report("result_rank", 32'(result_rank), 32'(want.rank));
                    if (entry_total !== want.total)
                        report("entry_total", 32'(entry_total), 32'(want.total));
                end
            end
            if (in_valid && !in_stall)
                answers_q.push_back(serve_request(mode, line, rank));
            pending = answers_q.size();
        end
    end

endmodule

@@ bench/tb_sorted_line_index_table.sv @@
`timescale 1ns / 1ps

module tb_sorted_line_index_table;
    import slit_pkg::*;

    localparam int LINE_BITS = LINE_BITS_DEF;
    localparam int CAPACITY  = CAPACITY_DEF;
    // mode codes the block has no operation for
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
    localparam logic [LINE_BITS-1:0] LINE_TOP  = '1;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int RANDOM_WORDS  = 360;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [MODE_W-1:0]    mode = '0;
    logic [LINE_BITS-1:0] line = '0;
    logic [RANK_W-1:0]    rank = '0;
    logic                 out_valid;
    logic                 out_stall;
    logic [STATUS_W-1:0]  status;
    logic [LINE_BITS-1:0] result_line;
    logic [RANK_W-1:0]    result_rank;
    logic [TOTAL_W-1:0]   entry_total;

    // out_stall merges the per-word receiver gaps with the long hold-off
    logic rx_gap  = 1'b0;
    logic hold_off = 1'b0;
    assign out_stall = rx_gap | hold_off;

    int fail_count;
    int pending;
    int sent_words  = 0;
    int taken_words = 0;
    int cycles      = 0;

    always #10 clk = ~clk;

    sorted_line_index_table #(
        .CAPACITY  (CAPACITY),
        .LINE_BITS (LINE_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .line        (line),
        .rank        (rank),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .result_line (result_line),
        .result_rank (result_rank),
        .entry_total (entry_total)
    );

    slit_checker #(
        .CAPACITY  (CAPACITY),
        .LINE_BITS (LINE_BITS)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .line        (line),
        .rank        (rank),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .result_line (result_line),
        .result_rank (result_rank),
        .entry_total (entry_total),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Watchdog: a hung block ends the run as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one word. Called at a falling edge; returns at the falling
    // edge after acceptance, leaving valid high so back-to-back words
    // need no drop. Every third stretch of 150 words goes without gaps.
    task automatic send_word(logic [MODE_W-1:0] m, logic [LINE_BITS-1:0] l,
                             logic [RANK_W-1:0] r);
        int gap;
        gap = ((sent_words / 150) % 3 == 2) ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        mode = m;
        line = l;
        rank = r;
        do
            @(posedge clk);
        while (in_stall);
        sent_words++;
        @(negedge clk);
    endtask

    // Random word: keys mostly from a small pool so hits are common,
    // sometimes full-width or near the extremes; clears keep the table short.
    task automatic send_random;
        int                   pick;
        int                   kind;
        logic [MODE_W-1:0]    m;
        logic [LINE_BITS-1:0] k;
        logic [RANK_W-1:0]    r;
        pick = $urandom_range(0, 99);
        kind = $urandom_range(0, 9);
        if (pick < 38)       m = MODE_INSERT;
        else if (pick < 52)  m = MODE_REMOVE;
        else if (pick < 64)  m = MODE_RANK_OF;
        else if (pick < 76)  m = MODE_SELECT;
        else if (pick < 88)  m = MODE_SUCC;
        else if (pick < 90)  m = MODE_CLEAR;
        else if (pick < 92)  m = MODE_SPARE_A;
        else if (pick < 94)  m = MODE_SPARE_B;
        else                 m = MODE_INSERT;
        if (kind < 6)        k = LINE_BITS'($urandom_range(0, 127));
        else if (kind < 8)   k = LINE_BITS'($urandom);
        else if (kind == 8)  k = LINE_TOP - LINE_BITS'($urandom_range(0, 3));
        else                 k = LINE_BITS'($urandom_range(0, 3));
        r = ($urandom_range(0, 3) == 0) ? RANK_W'($urandom)
                                        : RANK_W'($urandom_range(0, 80));
        send_word(m, k, r);
    endtask

    // Receiver: a fresh gap before every word, none in every third stretch.
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = ((taken_words / 170) % 3 == 1) ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                rx_gap = 1'b1;
                repeat (gap) @(negedge clk);
            end
            rx_gap = 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
            taken_words++;
            @(negedge clk);
        end
    end

    // Long hold-off so the block backs up and stalls its input.
    initial
    begin
        wait (sent_words >= 200);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        int idle;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, every mode, the present, absent and range cases
        send_word(MODE_SELECT,  '0, '0);          // select on empty
        send_word(MODE_SUCC,    '0, '0);          // successor on empty
        send_word(MODE_REMOVE,  '0, '0);          // remove on empty
        send_word(MODE_INSERT,  '0, '0);
        send_word(MODE_INSERT,  LINE_TOP, '1);
        send_word(MODE_INSERT,  '0, '0);          // already present
        send_word(MODE_INSERT,  24'h800000, '0);
        send_word(MODE_RANK_OF, '0, '0);
        send_word(MODE_RANK_OF, LINE_TOP, '0);
        send_word(MODE_RANK_OF, 24'h800000, '0);
        send_word(MODE_RANK_OF, 24'h000001, '0);  // missing
        send_word(MODE_REMOVE,  24'h000001, '0);  // missing
        send_word(MODE_SELECT,  '0, 10'd0);
        send_word(MODE_SELECT,  '0, 10'd2);
        send_word(MODE_SELECT,  '0, 10'd3);       // out of range
        send_word(MODE_SELECT,  '0, '1);          // out of range
        send_word(MODE_SUCC,    24'h000001, '0);
        send_word(MODE_SUCC,    24'h800001, '0);
        send_word(MODE_SPARE_A, 24'h123456, 10'h155);
        send_word(MODE_SPARE_B, LINE_TOP, '1);
        send_word(MODE_REMOVE,  LINE_TOP, '0);
        send_word(MODE_SUCC,    24'h800001, '0);  // none at or above
        send_word(MODE_REMOVE,  '0, '0);
        send_word(MODE_CLEAR,   '0, '0);

        repeat (RANDOM_WORDS) send_random();

        // full table: ascending inserts append, so filling stays cheap
        send_word(MODE_CLEAR, '0, '0);
        for (int i = 0; i < CAPACITY; i++)
            send_word(MODE_INSERT, LINE_BITS'(i * 16 + 5), '0);
        send_word(MODE_INSERT,  24'd3, '0);               // full
        send_word(MODE_INSERT,  24'd21, '0);              // present while full
        send_word(MODE_SELECT,  '0, '1);                  // top rank
        send_word(MODE_RANK_OF, LINE_BITS'((CAPACITY - 1) * 16 + 5), '0);
        send_word(MODE_SUCC,    LINE_TOP, '0);            // none
        send_word(MODE_SUCC,    '0, '0);
        send_word(MODE_REMOVE,  24'd5, '0);
        send_word(MODE_SELECT,  '0, '1);                  // now out of range
        send_word(MODE_INSERT,  LINE_TOP, '0);            // refill at the end
        send_word(MODE_INSERT,  24'd6, '0);               // full again
        send_word(MODE_CLEAR,   '0, '0);
        send_word(MODE_SUCC,    '0, '0);
        in_valid = 1'b0;

        // drain, then a little settle time for stray words
        wait (pending == 0);
        idle = 0;
        while (idle < 100)
        begin
            @(posedge clk);
            idle++;
        end
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
